/* hw/rtl/hbt_pkg.sv */
// Shared types, widths and constants for the histogram budget threshold block.
`default_nettype none

package hbt_pkg;

    // Histogram size default
    localparam int HIST_BINS_DEF = 128;

    // Bin and point counters, saturating
    localparam int CNT_W = 21;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Field widths
    localparam int MAX_PTS_W = 20;
    localparam int SCALE_W   = 16;
    localparam int AGE_W     = 16;
    localparam int AMP_W     = 16;
    localparam int WAVE_W    = 16;

    // Steepness products: amp*k is Q10.22, times Q8.8 scale, bin is bits above 30
    localparam int PROD1_W  = AMP_W + WAVE_W;
    localparam int PROD2_W  = PROD1_W + SCALE_W;
    localparam int BIN_FRAC = 30;
    localparam int RB_W     = PROD2_W - BIN_FRAC;

    // Scan target and running sum
    localparam int TARGET_W = CNT_W + 1;
    localparam int ACC_W    = CNT_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAX_PTS_W;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRESH_AGE    = 2'd2;

    localparam logic [MAX_PTS_W-1:0] POINT_BUDGET_RST = 20'd24000;
    localparam logic [SCALE_W-1:0]   BIN_SCALE_RST    = 16'd46811;
    localparam logic [AGE_W-1:0]     FRESH_AGE_RST    = 16'd205;

    // Item kinds
    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_MARK  = 1'b1;

    // Queues
    localparam int IN_Q_DEPTH  = 4;
    localparam int OUT_Q_DEPTH = 2;
    localparam int IQ_CNT_W    = $clog2(IN_Q_DEPTH + 1);
    localparam int OQ_CNT_W    = $clog2(OUT_Q_DEPTH + 1);

    // Back-end sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_SCAN_END
    } hbt_state_t;

    // Classified item flags carried from front to back
    typedef struct packed {
        logic func;
        logic last;
        logic fresh_ok;
        logic big;
    } hbt_flags_t;

    localparam int FLAGS_W = $bits(hbt_flags_t);

endpackage

`default_nettype wire

/* hw/rtl/histogram_budget_threshold_unit.sv */
// Top level of the histogram budget threshold unit: config registers and queues.
//
// Points arrive on a queue-style input (push/full) twice per frame: a counting
// pass (func 0) that fills a steepness histogram, then a marking pass (func 1)
// that returns one faded bit per point on a queue-style output (empty/pop).
// Configuration writes use cfg_valid/cfg_ready (always ready); the user must
// make them only while the unit is idle, which the unit does not enforce.
// Throughput: one point per cycle in both passes while no sweep runs and
// the result queue has room. Each point passes two multiplier stages, the
// item queue and then the back end. The counting beat marked last starts a
// sweep of the histogram memory that reads and clears every bin. No queued
// point is processed during it, so input backs up into the 4-entry item
// queue and full rises. After reset the unit clears the histogram memory,
// one bin a cycle, with full held high; configuration writes are taken.
// When the receiver stalls, results wait in a 2-entry output queue; once it
// fills, marking beats stall in the item queue and full follows.
`default_nettype none

module histogram_budget_threshold_unit #(
    parameter int HIST_BINS = hbt_pkg::HIST_BINS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            func,
    input  wire logic [hbt_pkg::AMP_W-1:0]       amplitude,
    input  wire logic [hbt_pkg::WAVE_W-1:0]      wavenumber,
    input  wire logic [hbt_pkg::AGE_W-1:0]       point_age,
    input  wire logic                            last,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 faded,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import hbt_pkg::*;

    localparam int BIN_W  = $clog2(HIST_BINS);
    localparam int IQ_W   = FLAGS_W + BIN_W;

    logic [MAX_PTS_W-1:0] point_budget_reg;
    logic [SCALE_W-1:0]   bin_scale_reg;
    logic [AGE_W-1:0]     fresh_age_reg;

    logic                 clearing;
    logic                 fq_push;
    hbt_flags_t           fq_flags;
    logic [BIN_W-1:0]     fq_bin;
    logic [IQ_CNT_W-1:0]  iq_count;
    logic [IQ_W-1:0]      iq_rd_data;
    hbt_flags_t           bq_flags;
    logic [BIN_W-1:0]     bq_bin;
    logic                 q_empty;
    logic                 q_pop;

    logic                 out_push;
    logic                 out_faded;
    logic                 out_full;
    logic [OQ_CNT_W-1:0]  oq_count;
    logic                 oq_pop;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_budget_reg <= POINT_BUDGET_RST;
            bin_scale_reg    <= BIN_SCALE_RST;
            fresh_age_reg    <= FRESH_AGE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POINT_BUDGET: point_budget_reg <= cfg_data[MAX_PTS_W-1:0];
                REG_BIN_SCALE:    bin_scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_FRESH_AGE:    fresh_age_reg    <= cfg_data[AGE_W-1:0];
                default:          point_budget_reg <= point_budget_reg;
            endcase
        end
    end

    // Front end
    hbt_front #(
        .HIST_BINS (HIST_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .amplitude  (amplitude),
        .wavenumber (wavenumber),
        .point_age  (point_age),
        .last       (last),
        .bin_scale  (bin_scale_reg),
        .fresh_age  (fresh_age_reg),
        .q_count    (iq_count),
        .clearing   (clearing),
        .q_push     (fq_push),
        .q_flags    (fq_flags),
        .q_bin      (fq_bin)
    );

    // Item queue between front and back
    hbt_fifo #(
        .WIDTH (IQ_W),
        .DEPTH (IN_Q_DEPTH)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_data ({fq_flags, fq_bin}),
        .pop     (q_pop),
        .rd_data (iq_rd_data),
        .count   (iq_count)
    );

    assign bq_flags = hbt_flags_t'(iq_rd_data[IQ_W-1 -: FLAGS_W]);
    assign bq_bin   = iq_rd_data[BIN_W-1:0];
    assign q_empty  = (iq_count == '0);

    // Back end
    hbt_back #(
        .HIST_BINS (HIST_BINS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_flags      (bq_flags),
        .q_bin        (bq_bin),
        .q_pop        (q_pop),
        .out_full     (out_full),
        .out_push     (out_push),
        .out_faded    (out_faded),
        .point_budget (point_budget_reg),
        .clearing     (clearing)
    );

    // Result queue
    hbt_fifo #(
        .WIDTH (1),
        .DEPTH (OUT_Q_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_faded),
        .pop     (oq_pop),
        .rd_data (faded),
        .count   (oq_count)
    );

    assign empty    = (oq_count == '0);
    assign oq_pop   = pop && !empty;
    assign out_full = (oq_count == OQ_CNT_W'(OUT_Q_DEPTH));

endmodule

`default_nettype wire

/* hw/rtl/hbt_fifo.sv */
// Small register FIFO with a fill count, used for the item and result queues.
`default_nettype none

module hbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int FILL_W = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              pop,
    output logic      [WIDTH-1:0]  rd_data,
    output logic      [FILL_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0]  store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] count_reg, count_next;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = store_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

`default_nettype wire

/* hw/rtl/hbt_front.sv */
// Front end: accepts points, computes the steepness bin and classifies each item.
`default_nettype none

module hbt_front #(
    parameter int HIST_BINS = hbt_pkg::HIST_BINS_DEF,
    localparam int BIN_W = $clog2(HIST_BINS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          func,
    input  wire logic [hbt_pkg::AMP_W-1:0]     amplitude,
    input  wire logic [hbt_pkg::WAVE_W-1:0]    wavenumber,
    input  wire logic [hbt_pkg::AGE_W-1:0]     point_age,
    input  wire logic                          last,
    input  wire logic [hbt_pkg::SCALE_W-1:0]   bin_scale,
    input  wire logic [hbt_pkg::AGE_W-1:0]     fresh_age,
    input  wire logic [hbt_pkg::IQ_CNT_W-1:0]  q_count,
    input  wire logic                          clearing,
    output logic                               q_push,
    output hbt_pkg::hbt_flags_t                q_flags,
    output logic      [BIN_W-1:0]              q_bin
);

    import hbt_pkg::*;

    localparam int OCC_W = IQ_CNT_W + 1;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);

    logic               accept;
    logic [OCC_W-1:0]   occupancy;
    logic [PROD2_W-1:0] prod2;
    logic               big;

    logic               s1_valid_reg;
    logic [PROD1_W-1:0] s1_prod_reg;
    logic               s1_func_reg;
    logic               s1_last_reg;
    logic               s1_fresh_ok_reg;

    logic               s2_valid_reg;
    logic [RB_W-1:0]    s2_rb_reg;
    logic               s2_func_reg;
    logic               s2_last_reg;
    logic               s2_fresh_ok_reg;

    // Hold off input when queue plus in-flight beats could overrun it
    assign occupancy = OCC_W'(q_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg);
    assign full      = clearing || (occupancy >= OCC_W'(IN_Q_DEPTH));
    assign accept    = push && !full;

    // Second product: steepness times scale
    assign prod2 = PROD2_W'(s1_prod_reg) * PROD2_W'(bin_scale);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_prod_reg     <= PROD1_W'(amplitude) * PROD1_W'(wavenumber);
        s1_func_reg     <= func;
        s1_last_reg     <= last;
        s1_fresh_ok_reg <= (point_age >= fresh_age);

        s2_rb_reg       <= prod2[PROD2_W-1 -: RB_W];
        s2_func_reg     <= s1_func_reg;
        s2_last_reg     <= s1_last_reg;
        s2_fresh_ok_reg <= s1_fresh_ok_reg;
    end

    // Clamp the raw bin; keep an out-of-range flag for the marking compare
    assign big               = (s2_rb_reg >= RB_W'(HIST_BINS));
    assign q_bin             = big ? LAST_BIN : s2_rb_reg[BIN_W-1:0];
    assign q_push            = s2_valid_reg;
    assign q_flags.func      = s2_func_reg;
    assign q_flags.last      = s2_last_reg;
    assign q_flags.fresh_ok  = s2_fresh_ok_reg;
    assign q_flags.big       = big;

endmodule

`default_nettype wire

/* hw/rtl/hbt_back.sv */
// Back end: histogram memory, bin counting, end-of-pass scan and fade decision.
`default_nettype none

module hbt_back #(
    parameter int HIST_BINS = hbt_pkg::HIST_BINS_DEF,
    localparam int BIN_W = $clog2(HIST_BINS)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_empty,
    input  wire hbt_pkg::hbt_flags_t            q_flags,
    input  wire logic [BIN_W-1:0]               q_bin,
    output logic                                q_pop,
    input  wire logic                           out_full,
    output logic                                out_push,
    output logic                                out_faded,
    input  wire logic [hbt_pkg::MAX_PTS_W-1:0]  point_budget,
    output logic                                clearing
);

    import hbt_pkg::*;

    localparam int THR_W = $clog2(HIST_BINS + 1);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);
    localparam logic [THR_W-1:0] THR_ALL  = THR_W'(HIST_BINS);

    hbt_state_t state_reg, state_next;

    // Sequencer outputs
    logic scanning;
    logic scan_end;
    logic count_pop;
    logic mark_pop;

    // Memory and its pipeline
    logic [CNT_W-1:0] hist_mem [HIST_BINS];
    logic [CNT_W-1:0] rd_data_reg;
    logic [BIN_W-1:0] rd_addr;
    logic             we;
    logic [BIN_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             fwd;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] cur_inc;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_scan_reg, s1_scan_next;
    logic [BIN_W-1:0] s1_addr_reg, s1_addr_next;
    logic             wr_valid_reg;
    logic [BIN_W-1:0] wr_addr_reg;
    logic [CNT_W-1:0] wr_data_reg;

    // Counters and scan state
    logic [BIN_W-1:0]    ctr_reg, ctr_next;
    logic [CNT_W-1:0]    pc_reg, pc_next;
    logic                over_reg, over_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    acc_sum;
    logic                found_reg, found_next;
    logic [THR_W-1:0]    thr_scan_reg, thr_scan_next;
    logic [CNT_W-1:0]    excess;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (ctr_reg == LAST_BIN)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (count_pop && q_flags.last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ctr_reg == LAST_BIN)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        clearing  = 1'b0;
        scanning  = 1'b0;
        scan_end  = 1'b0;
        q_pop     = 1'b0;
        count_pop = 1'b0;
        mark_pop  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            ST_RUN:
            begin
                q_pop     = !q_empty && ((q_flags.func == FUNC_COUNT) || !out_full);
                count_pop = q_pop && (q_flags.func == FUNC_COUNT);
                mark_pop  = q_pop && (q_flags.func == FUNC_MARK);
            end
            ST_SCAN:
            begin
                scanning = 1'b1;
            end
            ST_SCAN_END:
            begin
                scan_end = 1'b1;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // Read data with bypass of the write from the previous cycle
    assign fwd     = wr_valid_reg && (wr_addr_reg == s1_addr_reg);
    assign cur     = fwd ? wr_data_reg : rd_data_reg;
    assign cur_inc = (cur == CNT_MAX) ? cur : cur + CNT_W'(1);
    assign rd_addr = scanning ? ctr_reg : q_bin;

    // Single write port: clearing pass, count update or scan clear
    always_comb
    begin
        we    = 1'b0;
        waddr = s1_addr_reg;
        wdata = '0;
        if (clearing)
        begin
            we    = 1'b1;
            waddr = ctr_reg;
        end
        else if (s1_valid_reg)
        begin
            we    = 1'b1;
            wdata = s1_scan_reg ? '0 : cur_inc;
        end
    end

    // Datapath next values
    assign excess  = pc_reg - CNT_W'(point_budget);
    assign acc_sum = acc_reg + ACC_W'(cur);

    always_comb
    begin
        s1_valid_next = count_pop || scanning;
        s1_scan_next  = scanning;
        s1_addr_next  = rd_addr;
        ctr_next      = ctr_reg;
        pc_next       = pc_reg;
        over_next     = over_reg;
        thr_next      = thr_reg;
        target_next   = target_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        thr_scan_next = thr_scan_reg;

        // Address sweep for clearing and scanning
        if (clearing || scanning)
        begin
            ctr_next = (ctr_reg == LAST_BIN) ? '0 : ctr_reg + BIN_W'(1);
        end

        // Point count, saturating
        if (count_pop && (pc_reg != CNT_MAX))
        begin
            pc_next = pc_reg + CNT_W'(1);
        end

        // Scan setup on the first sweep cycle
        if (scanning && (ctr_reg == '0))
        begin
            over_next     = (pc_reg > CNT_W'(point_budget));
            target_next   = TARGET_W'(excess) + TARGET_W'(excess >> 2) + TARGET_W'(1);
            acc_next      = '0;
            found_next    = 1'b0;
            thr_scan_next = THR_ALL;
        end

        // Scan beat: running sum until the target is reached
        if (s1_valid_reg && s1_scan_reg && !found_reg)
        begin
            acc_next = acc_sum;
            if (acc_sum >= ACC_W'(target_reg))
            begin
                found_next    = 1'b1;
                thr_scan_next = THR_W'(s1_addr_reg) + THR_W'(1);
            end
        end

        // Commit threshold, start a new counting pass
        if (scan_end)
        begin
            thr_next = over_reg ? thr_scan_next : '0;
            pc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ctr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            pc_reg       <= '0;
            over_reg     <= 1'b0;
            thr_reg      <= THR_ALL;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ctr_reg      <= ctr_next;
            s1_valid_reg <= s1_valid_next;
            wr_valid_reg <= we;
            pc_reg       <= pc_next;
            over_reg     <= over_next;
            thr_reg      <= thr_next;
            found_reg    <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_scan_reg  <= s1_scan_next;
        s1_addr_reg  <= s1_addr_next;
        wr_addr_reg  <= waddr;
        wr_data_reg  <= wdata;
        target_reg   <= target_next;
        acc_reg      <= acc_next;
        thr_scan_reg <= thr_scan_next;
    end

    // Histogram memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[waddr] <= wdata;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // Fade decision for a marking beat
    assign out_push  = mark_pop;
    assign out_faded = over_reg && q_flags.fresh_ok && !q_flags.big
                       && (THR_W'(q_bin) < thr_reg);

endmodule

`default_nettype wire

/* tb/sv/hbt_fade_checker.sv */
// Fade-flag checker for the histogram budget threshold unit: predicts and compares beats.
module hbt_fade_checker #(
    parameter int HIST_BINS = hbt_pkg::HIST_BINS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic                           func,
    input  logic [hbt_pkg::AMP_W-1:0]      amplitude,
    input  logic [hbt_pkg::WAVE_W-1:0]     wavenumber,
    input  logic [hbt_pkg::AGE_W-1:0]      point_age,
    input  logic                           last,
    input  logic                           empty,
    input  logic                           pop,
    input  logic                           faded,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [hbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);

    import hbt_pkg::*;

    localparam int THR_W = $clog2(HIST_BINS + 1);

    // Shadow of the block's histogram and sweep results
    logic [CNT_W-1:0]     bin_tally [HIST_BINS];
    logic [CNT_W-1:0]     point_tally;
    logic [THR_W-1:0]     cut_bin;
    logic                 over_budget_q;

    // Shadow configuration
    logic [MAX_PTS_W-1:0] budget;
    logic [SCALE_W-1:0]   scale;
    logic [AGE_W-1:0]     fresh_limit;

    // Fade flags still owed by the block, oldest first
    logic                 fade_due [$];
    logic                 due_flag;

    // Unclamped bin: (amp * k * scale) >> 30, exact in 48 bits
    function automatic logic [RB_W-1:0] steep_bin(input logic [AMP_W-1:0] a,
                                                  input logic [WAVE_W-1:0] k);
        logic [PROD2_W-1:0] a_w;
        logic [PROD2_W-1:0] k_w;
        logic [PROD2_W-1:0] s_w;
        logic [PROD2_W-1:0] prod;
        a_w  = PROD2_W'(a);
        k_w  = PROD2_W'(k);
        s_w  = PROD2_W'(scale);
        prod = a_w * k_w * s_w;
        return prod[PROD2_W-1:BIN_FRAC];
    endfunction

    // End-of-pass sweep: pick the threshold bin, then clear everything
    task automatic sweep_histogram();
        logic [TARGET_W-1:0] excess;
        logic [TARGET_W-1:0] target;
        logic [ACC_W-1:0]    running;
        int                  b;
        over_budget_q = point_tally > CNT_W'(budget);
        if (over_budget_q)
        begin
            excess  = TARGET_W'(point_tally) - TARGET_W'(budget);
            target  = excess + (excess >> 2) + TARGET_W'(1);
            running = '0;
            b       = 0;
            while (b < HIST_BINS && running < ACC_W'(target))
            begin
                running = running + ACC_W'(bin_tally[b]);
                b++;
            end
            cut_bin = THR_W'(b);
        end
        else
        begin
            cut_bin = '0;
        end
        for (int i = 0; i < HIST_BINS; i++)
            bin_tally[i] = '0;
        point_tally = '0;
    endtask

    // Counting beat: saturating bin and point counters
    task automatic tally_point(input logic [AMP_W-1:0] a, input logic [WAVE_W-1:0] k,
                               input logic is_last);
        logic [RB_W-1:0] rb;
        int              idx;
        rb  = steep_bin(a, k);
        idx = (rb >= RB_W'(HIST_BINS)) ? HIST_BINS - 1 : int'(rb);
        if (bin_tally[idx] != CNT_MAX)
            bin_tally[idx] = bin_tally[idx] + CNT_W'(1);
        if (point_tally != CNT_MAX)
            point_tally = point_tally + CNT_W'(1);
        if (is_last)
            sweep_histogram();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_BINS; i++)
                bin_tally[i] = '0;
            point_tally   = '0;
            cut_bin       = THR_W'(HIST_BINS);
            over_budget_q = 1'b0;
            budget        = POINT_BUDGET_RST;
            scale         = BIN_SCALE_RST;
            fresh_limit   = FRESH_AGE_RST;
            fade_due.delete();
            fail_count    = 0;
            pending       = 0;
        end
        else
        begin
            // Result beat against the oldest owed flag
            if (pop && !empty)
            begin
                if (fade_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none actual faded=%0b",
                             $time, faded);
                end
                else
                begin
                    due_flag = fade_due.pop_front();
                    if (faded !== due_flag)
                    begin
                        fail_count++;
                        $display("%0t: faded mismatch, expected %0b actual %0b",
                                 $time, due_flag, faded);
                    end
                end
            end

            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POINT_BUDGET: budget      = cfg_data[MAX_PTS_W-1:0];
                    REG_BIN_SCALE:    scale       = cfg_data[SCALE_W-1:0];
                    REG_FRESH_AGE:    fresh_limit = cfg_data[AGE_W-1:0];
                    default: ;
                endcase
            end

            // Input beat
            if (push && !full)
            begin
                if (func == FUNC_COUNT)
                    tally_point(amplitude, wavenumber, last);
                else
                    fade_due.push_back(over_budget_q && point_age >= fresh_limit &&
                                       steep_bin(amplitude, wavenumber) < RB_W'(cut_bin));
            end
            pending = fade_due.size();
        end
    end

endmodule

/* tb/sv/tb_histogram_budget_threshold_unit.sv */
// Testbench top for the histogram budget threshold unit: clock, reset, stimulus and verdict.
module tb_histogram_budget_threshold_unit;
    import hbt_pkg::*;

    localparam int BINS          = HIST_BINS_DEF;
    localparam int SETTLE_CYCLES = BINS + 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_GAP       = 17;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  func;
    logic [AMP_W-1:0]      amplitude;
    logic [WAVE_W-1:0]     wavenumber;
    logic [AGE_W-1:0]      point_age;
    logic                  last;
    logic                  empty;
    logic                  pop;
    logic                  faded;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycles;
    int points_sent;
    int tx_max_gap;
    int rx_max_gap;
    int hold_reqs;

    // Stimulus-side copy of the fresh age written, to aim ages
    logic [AGE_W-1:0]      cur_fresh;

    histogram_budget_threshold_unit #(.HIST_BINS(BINS)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .amplitude  (amplitude),
        .wavenumber (wavenumber),
        .point_age  (point_age),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .faded      (faded),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    hbt_fade_checker #(.HIST_BINS(BINS)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .amplitude  (amplitude),
        .wavenumber (wavenumber),
        .point_age  (point_age),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .faded      (faded),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Log-spread magnitude so steepness lands across the whole bin range
    function automatic logic [15:0] rand_mag();
        logic [31:0] v;
        v = $urandom_range(0, 65535) >> $urandom_range(0, 16);
        return v[15:0];
    endfunction

    function automatic logic [15:0] rand_word();
        logic [31:0] v;
        v = $urandom;
        return v[15:0];
    endfunction

    // Ages either anywhere or hugging the fresh limit
    function automatic logic [AGE_W-1:0] rand_age();
        logic [31:0] v;
        if ($urandom_range(0, 1))
            v = $urandom;
        else
            v = 32'(cur_fresh) + $urandom_range(0, 8) - 32'd4;
        return v[AGE_W-1:0];
    endfunction

    // One input beat, after a random gap
    task automatic send_point(input logic f, input logic [AMP_W-1:0] a,
                              input logic [WAVE_W-1:0] k, input logic [AGE_W-1:0] g,
                              input logic l);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push       = 1'b1;
        func       = f;
        amplitude  = a;
        wavenumber = k;
        point_age  = g;
        last       = l;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        points_sent++;
    endtask

    // Register write, only while the unit is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == REG_FRESH_AGE)
            cur_fresh = d[AGE_W-1:0];
    endtask

    // Narrow registers get random upper data bits
    task automatic write_narrow(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        logic [31:0] d;
        d       = $urandom;
        d[15:0] = val;
        write_reg(idx, d[CFG_DATA_W-1:0]);
    endtask

    // Drain results and let the histogram sweep finish
    task automatic wait_idle();
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic count_pass(input int n);
        for (int i = 0; i < n; i++)
            send_point(FUNC_COUNT, rand_mag(), rand_mag(), rand_word(), i == n - 1);
    endtask

    task automatic mark_pass(input int n);
        for (int i = 0; i < n; i++)
            send_point(FUNC_MARK, rand_mag(), rand_mag(), rand_age(),
                       1'($urandom_range(0, 1)));
    endtask

    // Receiver: per-beat random wait, plus long hold-offs on request
    initial
    begin
        int   gap;
        int   pops;
        int   holds_done;
        logic need_gap;
        pop        = 1'b0;
        pops       = 0;
        holds_done = 0;
        need_gap   = 1'b1;
        rx_max_gap = MAX_GAP;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_reqs > holds_done)
            begin
                holds_done++;
                pop = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (need_gap)
            begin
                need_gap = 1'b0;
                gap = $urandom_range(0, rx_max_gap);
                if (gap > 0)
                begin
                    pop = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            pop = 1'b1;
            @(posedge clk);
            if (!empty)
            begin
                need_gap = 1'b1;
                pops++;
                if (pops % 40 == 0)
                    rx_max_gap = $urandom_range(0, 2) == 0 ? 0 : MAX_GAP;
            end
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int   frame_no;
        int   n_cnt;
        int   n_mark;
        int   start_pts;
        logic hold_frame;
        rst_n       = 1'b0;
        push        = 1'b0;
        func        = FUNC_COUNT;
        amplitude   = '0;
        wavenumber  = '0;
        point_age   = '0;
        last        = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_POINT_BUDGET;
        cfg_data    = '0;
        hold_reqs   = 0;
        tx_max_gap  = MAX_GAP;
        points_sent = 0;
        cur_fresh   = FRESH_AGE_RST;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Marking before any sweep: reset threshold, nothing fades
        send_point(FUNC_MARK, '0, '0, '0, 1'b1);
        send_point(FUNC_MARK, '1, '1, '1, 1'b0);

        // Within budget at reset settings: threshold drops to zero
        send_point(FUNC_COUNT, '0, '0, '0, 1'b0);
        send_point(FUNC_COUNT, '1, '1, '1, 1'b0);
        send_point(FUNC_COUNT, '1, '0, '0, 1'b0);
        send_point(FUNC_COUNT, '0, '1, '1, 1'b0);
        send_point(FUNC_COUNT, 16'd1, 16'd1, 16'h5555, 1'b0);
        send_point(FUNC_COUNT, 16'h0100, 16'h0040, 16'hAAAA, 1'b1);
        send_point(FUNC_MARK, '1, '1, '1, 1'b0);
        send_point(FUNC_MARK, 16'd1, 16'd1, 16'hFFFF, 1'b1);
        send_point(FUNC_MARK, '0, '0, '0, 1'b0);
        wait_idle();

        // Zero budget, zero scale: every point in bin 0, target never reached
        write_reg(REG_POINT_BUDGET, '0);
        write_narrow(REG_BIN_SCALE, '0);
        write_narrow(REG_FRESH_AGE, '0);
        write_reg(REG_SPARE, '1);
        count_pass(4);
        send_point(FUNC_MARK, '1, '1, '0, 1'b1);
        send_point(FUNC_MARK, '0, '0, '1, 1'b0);
        send_point(FUNC_MARK, 16'h8000, 16'h8000, 16'h0400, 1'b0);
        wait_idle();

        // Other extremes
        write_reg(REG_POINT_BUDGET, {MAX_PTS_W{1'b1}});
        write_narrow(REG_BIN_SCALE, '1);
        write_narrow(REG_FRESH_AGE, '1);

        // Random frames: counting pass, sweep, marking pass
        frame_no  = 0;
        start_pts = points_sent;
        while (points_sent - start_pts < RANDOM_ITEMS)
        begin
            frame_no++;
            n_cnt      = $urandom_range(3, 48);
            n_mark     = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(3, 48);
            tx_max_gap = $urandom_range(0, 3) == 0 ? 0 : MAX_GAP;
            hold_frame = (frame_no == 4 || frame_no == 18);
            if (hold_frame)
            begin
                n_mark     = 40;
                tx_max_gap = 0;
            end

            case ($urandom_range(0, 5))
                0, 1: write_reg(REG_POINT_BUDGET, CFG_DATA_W'($urandom_range(0, n_cnt - 1)));
                2:    write_reg(REG_POINT_BUDGET, CFG_DATA_W'($urandom_range(0, n_cnt + 8)));
                3:    write_reg(REG_POINT_BUDGET, '0);
                4:    write_reg(REG_POINT_BUDGET, $urandom_range(0, 1) ?
                                {MAX_PTS_W{1'b1}} : CFG_DATA_W'($urandom));
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: write_narrow(REG_BIN_SCALE, '0);
                1: write_narrow(REG_BIN_SCALE, '1);
                2: write_narrow(REG_BIN_SCALE, BIN_SCALE_RST);
                3: write_narrow(REG_BIN_SCALE, rand_word());
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: write_narrow(REG_FRESH_AGE, '0);
                1: write_narrow(REG_FRESH_AGE, '1);
                2: write_narrow(REG_FRESH_AGE, 16'($urandom_range(0, 2047)));
                3: write_narrow(REG_FRESH_AGE, rand_word());
                default: ;
            endcase

            count_pass(n_cnt);
            if (hold_frame)
                hold_reqs++;
            mark_pass(n_mark);
            wait_idle();
        end

        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/hbt_pkg.sv
hw/rtl/hbt_fifo.sv
hw/rtl/hbt_front.sv
hw/rtl/hbt_back.sv
hw/rtl/histogram_budget_threshold_unit.sv
tb/sv/hbt_fade_checker.sv
tb/sv/tb_histogram_budget_threshold_unit.sv
